>>> src/euler_zyx_rotation_matrix_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ZYX rotation matrix block
// Shared implication checks with synchronous reset disable.
// ---------------------------------------------------------------------------
`ifndef EULER_ZYX_ROTATION_MATRIX_TOP_ASSERT_SVH
`define EULER_ZYX_ROTATION_MATRIX_TOP_ASSERT_SVH

// Same-cycle implication.
`define EZRM_ASSERT_IMP(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) \
    else $error("ezrm same-cycle check failed");

// Next-cycle implication.
`define EZRM_ASSERT_NXT(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) \
    else $error("ezrm next-cycle check failed");

`endif

>>> src/ezrm_pkg.sv
// ---------------------------------------------------------------------------
// ZYX rotation matrix package
// Beat types, CORDIC constants and the arctangent table.
// ---------------------------------------------------------------------------
package ezrm_pkg;

  localparam int CORDIC_STAGES = 30;
  localparam int WORK_FRAC     = 30;
  localparam int TURN_BITS     = 32;
  localparam int XW            = 34;
  localparam int ANGLE_W       = 16;
  localparam int ENTRY_W       = 16;

  localparam logic signed [XW-1:0] CORDIC_START = 34'sd652032874;

  localparam logic [TURN_BITS-1:0] ATAN_TABLE [CORDIC_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_x;
    logic signed [ANGLE_W-1:0] angle_y;
    logic signed [ANGLE_W-1:0] angle_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [ENTRY_W-1:0] m00;
    logic signed [ENTRY_W-1:0] m01;
    logic signed [ENTRY_W-1:0] m02;
    logic signed [ENTRY_W-1:0] m10;
    logic signed [ENTRY_W-1:0] m11;
    logic signed [ENTRY_W-1:0] m12;
    logic signed [ENTRY_W-1:0] m20;
    logic signed [ENTRY_W-1:0] m21;
    logic signed [ENTRY_W-1:0] m22;
  } out_beat_t;

endpackage

>>> src/ezrm_cordic.sv
// ---------------------------------------------------------------------------
// Pipelined sine and cosine unit
// Rotation-mode CORDIC, one stage per iteration, with quadrant fold,
// rounding and clamping to the output fraction width.
// ---------------------------------------------------------------------------
module ezrm_cordic
  import ezrm_pkg::*;
#(
  parameter int ANGLE_BITS    = 16,
  parameter int FRACTION_BITS = 14
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ANGLE_BITS-1:0]         angle,
  output logic signed [FRACTION_BITS+1:0] sin_v,
  output logic signed [FRACTION_BITS+1:0] cos_v
);

  localparam int SW    = FRACTION_BITS + 2;
  localparam int SHIFT = WORK_FRAC - FRACTION_BITS;
  localparam logic signed [XW-1:0] HALF_X = XW'((64'(1) << SHIFT) >> 1);
  localparam logic signed [XW-1:0] ONE_X  = XW'(64'(1) << FRACTION_BITS);

  logic [TURN_BITS-1:0] turn;
  logic                 fold;
  logic [TURN_BITS-1:0] turn_f;

  logic signed [XW-1:0] x [CORDIC_STAGES+1];
  logic signed [XW-1:0] y [CORDIC_STAGES+1];
  logic signed [XW-1:0] z [CORDIC_STAGES+1];
  logic                 flip [CORDIC_STAGES+1];

  logic signed [XW-1:0] xn;
  logic signed [XW-1:0] yn;
  logic signed [XW-1:0] xr;
  logic signed [XW-1:0] yr;

  assign turn   = {angle, {(TURN_BITS-ANGLE_BITS){1'b0}}};
  assign fold   = turn[TURN_BITS-1] ^ turn[TURN_BITS-2];
  assign turn_f = {turn[TURN_BITS-1] ^ fold, turn[TURN_BITS-2:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= CORDIC_START;
      y[0]    <= '0;
      z[0]    <= XW'($signed(turn_f));
      flip[0] <= fold;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        flip[i+1] <= flip[i];
        if (!z[i][XW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - XW'(ATAN_TABLE[i]);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + XW'(ATAN_TABLE[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xn <= flip[CORDIC_STAGES] ? -x[CORDIC_STAGES] : x[CORDIC_STAGES];
      yn <= flip[CORDIC_STAGES] ? -y[CORDIC_STAGES] : y[CORDIC_STAGES];
    end
  end

  assign xr = (xn + HALF_X) >>> SHIFT;
  assign yr = (yn + HALF_X) >>> SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (xr > ONE_X) begin
        cos_v <= SW'(ONE_X);
      end else if (xr < -ONE_X) begin
        cos_v <= SW'(-ONE_X);
      end else begin
        cos_v <= SW'(xr);
      end
      if (yr > ONE_X) begin
        sin_v <= SW'(ONE_X);
      end else if (yr < -ONE_X) begin
        sin_v <= SW'(-ONE_X);
      end else begin
        sin_v <= SW'(yr);
      end
    end
  end

endmodule

>>> src/euler_zyx_rotation_matrix_top.sv
// ---------------------------------------------------------------------------
// ZYX Euler angle rotation matrix
// Turns three binary angles into the nine entries of Rz*Ry*Rx.
// ---------------------------------------------------------------------------
// The block accepts one beat of three angles per clock and returns one beat
// of nine matrix entries per clock while the pipeline is not stalled. The
// pipeline runs through the 30 CORDIC iterations, each of which is its own
// register stage, followed by the rounding stages and two levels of
// multipliers. A stall on the output while out_valid is high freezes the whole
// pipeline, and the input stall follows it in the same cycle.
module euler_zyx_rotation_matrix_top
  import ezrm_pkg::*;
#(
  parameter int ANGLE_BITS    = 16,
  parameter int FRACTION_BITS = 14
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  `include "euler_zyx_rotation_matrix_top_assert.svh"

  localparam int SW    = FRACTION_BITS + 2;
  localparam int PW    = 2 * SW;
  localparam int RW    = FRACTION_BITS + 3;
  localparam int MW    = SW + RW + 1;
  localparam int LAT_L = CORDIC_STAGES + 3;
  localparam int DEPTH = LAT_L + 5;

  localparam logic signed [PW-1:0] HALF_P = PW'((64'(1) << FRACTION_BITS) >> 1);
  localparam logic signed [MW-1:0] HALF_M = MW'((64'(1) << FRACTION_BITS) >> 1);
  localparam logic signed [MW-1:0] ONE_M  = MW'(64'(1) << FRACTION_BITS);
  localparam logic signed [SW-1:0] ONE_S  = SW'(64'(1) << FRACTION_BITS);

  logic             en;
  logic [DEPTH-1:0] vld;

  logic signed [SW-1:0] sx, cx, sy, cy, sz, cz;
  logic signed [SW-1:0] s1_sx, s1_cx, s1_sy, s1_cy, s1_sz, s1_cz;
  logic signed [SW-1:0] s2_sx, s2_cx, s2_sy, s2_cy, s2_sz, s2_cz;
  logic signed [PW-1:0] p_sysx, p_sycx;
  logic signed [PW-1:0] r_sysx_w, r_sycx_w;
  logic signed [RW-1:0] r_sysx, r_sycx;

  logic signed [MW-1:0] q_czsysx, q_szcx, q_czsycx, q_szsx, q_czcy, q_szcy;
  logic signed [MW-1:0] q_szsysx, q_czcx, q_szsycx, q_czsx, q_cysx, q_cycx;
  logic signed [SW-1:0] neg_sy3, neg_sy4;

  logic signed [MW-1:0] e00, e01, e02, e10, e11, e12, e21, e22;

  function automatic logic signed [SW-1:0] finish(input logic signed [MW-1:0] v);
    logic signed [MW-1:0] r;
    r = (v + HALF_M) >>> FRACTION_BITS;
    if (r > ONE_M) begin
      r = ONE_M;
    end else if (r < -ONE_M) begin
      r = -ONE_M;
    end
    return SW'(r);
  endfunction

  function automatic logic signed [ENTRY_W-1:0] to_entry(input logic signed [SW-1:0] v);
    logic signed [63:0] t;
    t = 64'(v);
    return t[ENTRY_W-1:0];
  endfunction

  assign en       = !(vld[DEPTH-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  ezrm_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_lane_x (
    .clk(clk), .en(en), .angle(ANGLE_BITS'(in_data.angle_x)), .sin_v(sx), .cos_v(cx)
  );
  ezrm_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_lane_y (
    .clk(clk), .en(en), .angle(ANGLE_BITS'(in_data.angle_y)), .sin_v(sy), .cos_v(cy)
  );
  ezrm_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_lane_z (
    .clk(clk), .en(en), .angle(ANGLE_BITS'(in_data.angle_z)), .sin_v(sz), .cos_v(cz)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      p_sysx <= sy * sx;
      p_sycx <= sy * cx;
      s1_sx  <= sx;
      s1_cx  <= cx;
      s1_sy  <= sy;
      s1_cy  <= cy;
      s1_sz  <= sz;
      s1_cz  <= cz;
    end
  end

  assign r_sysx_w = (p_sysx + HALF_P) >>> FRACTION_BITS;
  assign r_sycx_w = (p_sycx + HALF_P) >>> FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      r_sysx <= RW'(r_sysx_w);
      r_sycx <= RW'(r_sycx_w);
      s2_sx  <= s1_sx;
      s2_cx  <= s1_cx;
      s2_sy  <= s1_sy;
      s2_cy  <= s1_cy;
      s2_sz  <= s1_sz;
      s2_cz  <= s1_cz;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_czsysx <= s2_cz * r_sysx;
      q_szcx   <= s2_sz * s2_cx;
      q_czsycx <= s2_cz * r_sycx;
      q_szsx   <= s2_sz * s2_sx;
      q_czcy   <= s2_cz * s2_cy;
      q_szcy   <= s2_sz * s2_cy;
      q_szsysx <= s2_sz * r_sysx;
      q_czcx   <= s2_cz * s2_cx;
      q_szsycx <= s2_sz * r_sycx;
      q_czsx   <= s2_cz * s2_sx;
      q_cysx   <= s2_cy * s2_sx;
      q_cycx   <= s2_cy * s2_cx;
      neg_sy3  <= -s2_sy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e00     <= q_czcy;
      e01     <= q_czsysx - q_szcx;
      e02     <= q_czsycx + q_szsx;
      e10     <= q_szcy;
      e11     <= q_szsysx + q_czcx;
      e12     <= q_szsycx - q_czsx;
      e21     <= q_cysx;
      e22     <= q_cycx;
      neg_sy4 <= neg_sy3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.m00 <= to_entry(finish(e00));
      out_data.m01 <= to_entry(finish(e01));
      out_data.m02 <= to_entry(finish(e02));
      out_data.m10 <= to_entry(finish(e10));
      out_data.m11 <= to_entry(finish(e11));
      out_data.m12 <= to_entry(finish(e12));
      out_data.m20 <= to_entry(neg_sy4);
      out_data.m21 <= to_entry(finish(e21));
      out_data.m22 <= to_entry(finish(e22));
    end
  end

  `EZRM_ASSERT_IMP(a_stall_source, clk, rst, in_stall, out_valid && out_stall)
  `EZRM_ASSERT_NXT(a_lane_advance, clk, rst, vld[LAT_L-1] && en, vld[LAT_L])
  `EZRM_ASSERT_IMP(a_sin_range, clk, rst, vld[LAT_L-1], (sx <= ONE_S) && (sx >= -ONE_S))

endmodule
